/* src/drq_pkg.sv */
// ----------------------------------------------------------------------------
// drq_pkg
// Shared types and codes for the dual ring queue with batch drain: command
// and status codes, the input and result beat layouts, the classified
// command passed from the front end to the execution unit, and statistic
// counter indexes.
// ----------------------------------------------------------------------------
package drq_pkg;

	// Input command codes
	typedef enum logic [2:0] {
		CMD_SUB_PUSH = 3'd0,
		CMD_SUB_POP  = 3'd1,
		CMD_CPL_PUSH = 3'd2,
		CMD_DRAIN    = 3'd3,
		CMD_STAT     = 3'd4
	} cmd_code_t;

	// Result status codes
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	// Operations after classification
	typedef enum logic [2:0] {
		OP_SUB_PUSH,
		OP_SUB_POP,
		OP_CPL_PUSH,
		OP_DRAIN,
		OP_STAT,
		OP_NOP
	} op_t;

	localparam int unsigned BATCH_W   = 5;
	localparam int unsigned SEL_W     = 4;
	localparam int unsigned WORD_W    = 64;
	localparam int unsigned NUM_STATS = 10;
	localparam logic [BATCH_W-1:0] MAX_BATCH = 5'd16;

	// Statistic counter indexes
	localparam int unsigned STAT_SUB_FULL     = 0;
	localparam int unsigned STAT_SUB_PUSH     = 1;
	localparam int unsigned STAT_SUB_PUBLISH  = 2;
	localparam int unsigned STAT_CPL_FULL     = 3;
	localparam int unsigned STAT_CPL_PUBLISH  = 4;
	localparam int unsigned STAT_DRAIN_CALLS  = 5;
	localparam int unsigned STAT_DRAIN_EMPTY  = 6;
	localparam int unsigned STAT_DRAIN_ENTRIES = 7;
	localparam int unsigned STAT_HEAD_PUBLISH = 8;
	localparam int unsigned STAT_BATCH_MAX    = 9;

	typedef struct packed {
		logic [2:0]         command;
		logic [WORD_W-1:0]  payload;
		logic [BATCH_W-1:0] drain_limit;
		logic [SEL_W-1:0]   stat_select;
	} in_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              has_entry;
		logic [WORD_W-1:0] entry_data;
		logic              last;
		logic [WORD_W-1:0] stat_value;
	} res_t;

	typedef struct packed {
		op_t                op;
		logic [WORD_W-1:0]  payload;
		logic [BATCH_W-1:0] batch;
		logic [SEL_W-1:0]   sel;
	} cmd_t;

endpackage

/* src/drq_front.sv */
// ----------------------------------------------------------------------------
// drq_front
// Front end: accepts input beats, classifies the command, clamps the drain
// batch size and queues the result in a two-entry command queue for the
// execution unit. Undefined command codes are accepted and dropped.
// ----------------------------------------------------------------------------
module drq_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  drq_pkg::in_t   item,
	output logic           cmd_valid,
	output drq_pkg::cmd_t  cmd,
	input  logic           cmd_pop
);

	drq_pkg::cmd_t q_mem [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;

	drq_pkg::cmd_t cls;
	logic          keep;
	logic          q_wr;
	logic          q_rd;

	// Classify the incoming command
	always_comb begin
		cls.payload = item.payload;
		cls.sel     = item.stat_select;
		cls.batch   = (item.drain_limit > drq_pkg::MAX_BATCH) ? drq_pkg::MAX_BATCH
			: item.drain_limit;
		cls.op      = drq_pkg::OP_NOP;
		keep        = 1'b1;
		case (item.command)
			drq_pkg::CMD_SUB_PUSH: cls.op = drq_pkg::OP_SUB_PUSH;
			drq_pkg::CMD_SUB_POP:  cls.op = drq_pkg::OP_SUB_POP;
			drq_pkg::CMD_CPL_PUSH: cls.op = drq_pkg::OP_CPL_PUSH;
			drq_pkg::CMD_DRAIN: begin
				cls.op = (item.drain_limit == '0) ? drq_pkg::OP_NOP : drq_pkg::OP_DRAIN;
			end
			drq_pkg::CMD_STAT:     cls.op = drq_pkg::OP_STAT;
			default:               keep = 1'b0;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_mem[rd_q];
	assign q_wr      = push && !full && keep;
	assign q_rd      = cmd_pop && cmd_valid;

	// Advance queue cursors and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (q_wr)
				wr_q <= ~wr_q;
			if (q_rd)
				rd_q <= ~rd_q;
			if (q_wr && !q_rd)
				cnt_q <= cnt_q + 2'd1;
			else if (!q_wr && q_rd)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// Hold queued commands
	always_ff @(posedge clk) begin
		if (q_wr)
			q_mem[wr_q] <= cls;
	end

endmodule

/* src/drq_back.sv */
// ----------------------------------------------------------------------------
// drq_back
// Execution unit: owns both ring memories, their cursors and the statistic
// counters. Push and read commands finish from idle; a submission pop emits from
// the registered read port; a drain emits one entry per cycle unless res_full.
// ----------------------------------------------------------------------------
module drq_back #(
	parameter int unsigned RING_DEPTH = 16,
	parameter int unsigned ENTRY_BITS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  drq_pkg::cmd_t  cmd,
	output logic           cmd_pop,
	output logic           res_push,
	output drq_pkg::res_t  res_d,
	input  logic           res_full
);

	localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned PTR_W = IDX_W + 1;
	localparam int unsigned CMP_W = (PTR_W > drq_pkg::BATCH_W) ? PTR_W : drq_pkg::BATCH_W;
	localparam int unsigned NS    = drq_pkg::NUM_STATS;
	localparam int unsigned BW    = drq_pkg::BATCH_W;
	localparam int unsigned WW    = drq_pkg::WORD_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_DRAIN
	} state_t;

	state_t            state_q, state_d;
	logic [PTR_W-1:0]  sub_rp_q, sub_rp_d, sub_wp_q, sub_wp_d;
	logic [PTR_W-1:0]  cpl_rp_q, cpl_rp_d, cpl_wp_q, cpl_wp_d;
	logic [BW-1:0]     remain_q, remain_d;
	logic [WW-1:0]     stat_q [NS];

	logic [ENTRY_BITS-1:0] sub_mem [RING_DEPTH];
	logic [ENTRY_BITS-1:0] cpl_mem [RING_DEPTH];
	logic [ENTRY_BITS-1:0] sub_rdata_q;
	logic [ENTRY_BITS-1:0] cpl_rdata_q;

	logic [PTR_W-1:0]  sub_fill, cpl_fill;
	logic              sub_is_full, sub_is_empty, cpl_is_full, cpl_is_empty;
	logic [CMP_W-1:0]  avail_w, batch_w;
	logic [BW-1:0]     take;
	logic              go;
	logic              sub_we, cpl_we;
	logic [NS-1:0]     stat_inc;
	logic              drained_add;
	logic              batch_upd;

	// Ring occupancy
	always_comb begin
		sub_fill     = sub_wp_q - sub_rp_q;
		cpl_fill     = cpl_wp_q - cpl_rp_q;
		sub_is_full  = (sub_fill == PTR_W'(RING_DEPTH));
		cpl_is_full  = (cpl_fill == PTR_W'(RING_DEPTH));
		sub_is_empty = (sub_fill == '0);
		cpl_is_empty = (cpl_fill == '0);
		avail_w      = CMP_W'(cpl_fill);
		batch_w      = CMP_W'(cmd.batch);
		take         = (avail_w < batch_w) ? BW'(cpl_fill) : cmd.batch;
	end

	assign go = (state_q == S_IDLE) && cmd_valid && !res_full;

	// Execute the current command and form the result beat
	always_comb begin
		state_d     = state_q;
		sub_rp_d    = sub_rp_q;
		sub_wp_d    = sub_wp_q;
		cpl_rp_d    = cpl_rp_q;
		cpl_wp_d    = cpl_wp_q;
		remain_d    = remain_q;
		cmd_pop     = 1'b0;
		res_push    = 1'b0;
		res_d       = '0;
		res_d.last  = 1'b1;
		sub_we      = 1'b0;
		cpl_we      = 1'b0;
		stat_inc    = '0;
		drained_add = 1'b0;
		batch_upd   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (go) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						drq_pkg::OP_SUB_PUSH: begin
							res_push = 1'b1;
							if (sub_is_full) begin
								res_d.status = drq_pkg::STATUS_FULL;
								stat_inc[drq_pkg::STAT_SUB_FULL] = 1'b1;
							end else begin
								sub_we   = 1'b1;
								sub_wp_d = sub_wp_q + PTR_W'(1);
								stat_inc[drq_pkg::STAT_SUB_PUSH]    = 1'b1;
								stat_inc[drq_pkg::STAT_SUB_PUBLISH] = 1'b1;
							end
						end
						drq_pkg::OP_CPL_PUSH: begin
							res_push = 1'b1;
							if (cpl_is_full) begin
								res_d.status = drq_pkg::STATUS_FULL;
								stat_inc[drq_pkg::STAT_CPL_FULL] = 1'b1;
							end else begin
								cpl_we   = 1'b1;
								cpl_wp_d = cpl_wp_q + PTR_W'(1);
								stat_inc[drq_pkg::STAT_CPL_PUBLISH] = 1'b1;
							end
						end
						drq_pkg::OP_SUB_POP: begin
							if (sub_is_empty) begin
								res_push     = 1'b1;
								res_d.status = drq_pkg::STATUS_EMPTY;
							end else begin
								state_d = S_POP;
							end
						end
						drq_pkg::OP_DRAIN: begin
							stat_inc[drq_pkg::STAT_DRAIN_CALLS] = 1'b1;
							if (cpl_is_empty) begin
								res_push     = 1'b1;
								res_d.status = drq_pkg::STATUS_EMPTY;
								stat_inc[drq_pkg::STAT_DRAIN_EMPTY] = 1'b1;
							end else begin
								remain_d    = take;
								drained_add = 1'b1;
								batch_upd   = 1'b1;
								stat_inc[drq_pkg::STAT_HEAD_PUBLISH] = 1'b1;
								state_d     = S_DRAIN;
							end
						end
						drq_pkg::OP_STAT: begin
							res_push = 1'b1;
							if (32'(cmd.sel) < NS)
								res_d.stat_value = stat_q[cmd.sel];
						end
						default: begin
							res_push = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				if (!res_full) begin
					res_push         = 1'b1;
					res_d.has_entry  = 1'b1;
					res_d.entry_data = WW'(sub_rdata_q);
					sub_rp_d         = sub_rp_q + PTR_W'(1);
					state_d          = S_IDLE;
				end
			end
			S_DRAIN: begin
				if (!res_full) begin
					res_push         = 1'b1;
					res_d.has_entry  = 1'b1;
					res_d.entry_data = WW'(cpl_rdata_q);
					res_d.last       = (remain_q == BW'(1));
					cpl_rp_d         = cpl_rp_q + PTR_W'(1);
					remain_d         = remain_q - BW'(1);
					if (remain_q == BW'(1))
						state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state, cursors and statistic counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sub_rp_q <= '0;
			sub_wp_q <= '0;
			cpl_rp_q <= '0;
			cpl_wp_q <= '0;
			remain_q <= '0;
			for (int i = 0; i < NS; i++)
				stat_q[i] <= '0;
		end else begin
			state_q  <= state_d;
			sub_rp_q <= sub_rp_d;
			sub_wp_q <= sub_wp_d;
			cpl_rp_q <= cpl_rp_d;
			cpl_wp_q <= cpl_wp_d;
			remain_q <= remain_d;
			for (int i = 0; i < NS; i++) begin
				if (stat_inc[i])
					stat_q[i] <= stat_q[i] + WW'(1);
			end
			if (drained_add)
				stat_q[drq_pkg::STAT_DRAIN_ENTRIES] <=
					stat_q[drq_pkg::STAT_DRAIN_ENTRIES] + WW'(take);
			if (batch_upd && (WW'(take) > stat_q[drq_pkg::STAT_BATCH_MAX]))
				stat_q[drq_pkg::STAT_BATCH_MAX] <= WW'(take);
		end
	end

	// Ring memories; read port follows the next read cursor
	always_ff @(posedge clk) begin
		if (sub_we)
			sub_mem[sub_wp_q[IDX_W-1:0]] <= cmd.payload[ENTRY_BITS-1:0];
		if (cpl_we)
			cpl_mem[cpl_wp_q[IDX_W-1:0]] <= cmd.payload[ENTRY_BITS-1:0];
		sub_rdata_q <= sub_mem[sub_rp_d[IDX_W-1:0]];
		cpl_rdata_q <= cpl_mem[cpl_rp_d[IDX_W-1:0]];
	end

endmodule

/* src/drq_res_q.sv */
// ----------------------------------------------------------------------------
// drq_res_q
// Two-entry result queue between the execution unit and the result port,
// so the unit keeps working while a finished beat waits to be taken.
// ----------------------------------------------------------------------------
module drq_res_q (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  drq_pkg::res_t  wr_data,
	output logic           full,
	output logic           empty,
	input  logic           pop,
	output drq_pkg::res_t  result
);

	drq_pkg::res_t q_mem [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full   = (cnt_q == 2'd2);
	assign empty  = (cnt_q == 2'd0);
	assign result = q_mem[rd_q];
	assign do_wr  = wr && !full;
	assign do_rd  = pop && !empty;

	// Advance cursors and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr)
				wr_q <= ~wr_q;
			if (do_rd)
				rd_q <= ~rd_q;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 2'd1;
			else if (!do_wr && do_rd)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// Hold waiting result beats
	always_ff @(posedge clk) begin
		if (do_wr)
			q_mem[wr_q] <= wr_data;
	end

endmodule

/* src/dual_ring_queue_with_batch_drain_unit.sv */
// A push, statistic read or empty result passes through the command and result queues;
// a submission pop result and each drain entry also pass the registered ring read port.
// One push or read is executed per cycle while the result queue has room; a pop or drain
// holds the single execution unit until its last entry is emitted.
// Reset clears cursors, statistic counters and both beat queues; ring storage is not
// cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// dual_ring_queue_with_batch_drain_unit
// Submission and completion ring queues with batch drain and statistics.
// Front end classifies commands, execution unit runs them, result queue
// decouples the result port.
// ----------------------------------------------------------------------------
module dual_ring_queue_with_batch_drain_unit #(
	parameter int unsigned RING_DEPTH = 16,
	parameter int unsigned ENTRY_BITS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  drq_pkg::in_t   item,
	output logic           empty,
	input  logic           pop,
	output drq_pkg::res_t  result
);

	logic          cmd_valid;
	drq_pkg::cmd_t cmd;
	logic          cmd_pop;
	logic          res_push;
	drq_pkg::res_t res_d;
	logic          res_full;

	// Accept and classify
	drq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Execute
	drq_back #(
		.RING_DEPTH (RING_DEPTH),
		.ENTRY_BITS (ENTRY_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res_d     (res_d),
		.res_full  (res_full)
	);

	// Buffer result beats
	drq_res_q u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_push),
		.wr_data (res_d),
		.full    (res_full),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

/* src/drq_checker.sv */
// ----------------------------------------------------------------------------
// drq_checker
// Port-level checks on the result stream of the ring queue unit, bound to
// the top level.
// ----------------------------------------------------------------------------
module drq_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  logic           pop,
	input  drq_pkg::res_t  result
);

	// A waiting result beat holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result beat changed while stalled");

	// An entry beat is always ok and carries no statistic
	a_entry_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.has_entry |->
			result.status == drq_pkg::STATUS_OK && result.stat_value == '0)
		else $error("entry beat with bad status or statistic");

	// A full or empty refusal is a single final beat without data
	a_refusal_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status != drq_pkg::STATUS_OK |->
			result.last && !result.has_entry && result.entry_data == '0)
		else $error("refusal beat not final or carries data");

	// A beat without entry always ends its command
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.has_entry |-> result.last)
		else $error("non-entry beat not marked last");

endmodule

bind dual_ring_queue_with_batch_drain_unit drq_checker u_drq_checker (.*);
